// ----- rtl/core/ffca_pkg.sv -----
`timescale 1ns / 1ps

package ffca_pkg;

	// Chain length and derived widths
	localparam int MAX_CHUNKS  = 64;
	localparam int IDX_W       = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int CNT_W       = $clog2(MAX_CHUNKS + 1);

	// Fixed field widths
	localparam int REQ_W       = 8;
	localparam int BYTES_W     = 17;
	localparam int CHUNK_IDX_W = 6;
	localparam int STATUS_W    = 2;

	localparam logic [BYTES_W-1:0] CHUNK_BYTES_RST = BYTES_W'(100);

	// Status codes
	localparam logic [STATUS_W-1:0] ST_PLACED    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	// Request token handed from cell to cell
	typedef struct packed {
		logic               valid;
		logic [REQ_W-1:0]   req;
		logic [IDX_W-1:0]   idx;       // index of the cell the token enters
		logic               placed;
		logic               opened;
		logic [IDX_W-1:0]   hit_idx;
		logic [BYTES_W-1:0] offset;
	} token_t;

	// Settings shared by every cell; user keeps them stable while a token is in flight (not enforced)
	typedef struct packed {
		logic [BYTES_W-1:0] chunk_bytes;
		logic [CNT_W-1:0]   open_cnt;
	} chain_ctx_t;

endpackage

// ----- rtl/core/first_fit_chunk_allocator_top.sv -----
`timescale 1ns / 1ps
// A request that fits a chunk passes the token register of each of the 64 chunk cells
// and then the result register; a too_large request goes straight to the result register.
// A new request is accepted only while busy is low, so one request walks the chain at a time.
// busy is high while a request is in the chain; results show on done for one cycle.
// The receiver cannot stall. Reset (arst_n low) closes all chunks, sets chunk_bytes
// to 100 and clears busy and done; per-chunk free counts are rewritten on opening.

module first_fit_chunk_allocator_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ffca_pkg::BYTES_W-1:0]     cfg_wdata,
	input  logic                             start,
	output logic                             busy,
	input  logic [ffca_pkg::REQ_W-1:0]       request_bytes,
	output logic                             done,
	output logic [ffca_pkg::CHUNK_IDX_W-1:0] chunk_index,
	output logic [ffca_pkg::BYTES_W-1:0]     byte_offset,
	output logic                             opened_new,
	output logic [ffca_pkg::STATUS_W-1:0]    status
);
	import ffca_pkg::*;

	logic [BYTES_W-1:0]     chunk_bytes_q;
	logic [CNT_W-1:0]       open_cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [CHUNK_IDX_W-1:0] chunk_index_q;
	logic [BYTES_W-1:0]     byte_offset_q;
	logic                   opened_new_q;
	logic [STATUS_W-1:0]    status_q;
	logic                   accept;
	logic                   too_large;
	chain_ctx_t             ctx;
	token_t                 tok_in;
	token_t                 tok_out;

	// Request transfer and size check
	assign accept    = start && !busy_q;
	assign too_large = BYTES_W'(request_bytes) > chunk_bytes_q;

	assign ctx.chunk_bytes = chunk_bytes_q;
	assign ctx.open_cnt    = open_cnt_q;

	// Token entering the first cell
	always_comb begin
		tok_in         = '0;
		tok_in.valid   = accept && !too_large;
		tok_in.req     = request_bytes;
	end

	ffca_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctx     (ctx),
		.tok_in  (tok_in),
		.tok_out (tok_out)
	);

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_bytes_q <= CHUNK_BYTES_RST;
		end else if (cfg_we) begin
			chunk_bytes_q <= cfg_wdata;
		end
	end

	// Control: busy flag, open count, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			open_cnt_q <= '0;
		end else begin
			done_q <= (accept && too_large) || tok_out.valid;
			if (tok_out.valid) begin
				busy_q <= 1'b0;
			end else if (accept && !too_large) begin
				busy_q <= 1'b1;
			end
			if (tok_out.valid && tok_out.placed && tok_out.opened) begin
				open_cnt_q <= open_cnt_q + 1'b1;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (tok_out.valid) begin
			if (tok_out.placed) begin
				chunk_index_q <= CHUNK_IDX_W'(tok_out.hit_idx);
				byte_offset_q <= tok_out.offset;
				opened_new_q  <= tok_out.opened;
				status_q      <= ST_PLACED;
			end else begin
				chunk_index_q <= '0;
				byte_offset_q <= '0;
				opened_new_q  <= 1'b0;
				status_q      <= ST_FULL;
			end
		end else if (accept && too_large) begin
			chunk_index_q <= '0;
			byte_offset_q <= '0;
			opened_new_q  <= 1'b0;
			status_q      <= ST_TOO_LARGE;
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign chunk_index = chunk_index_q;
	assign byte_offset = byte_offset_q;
	assign opened_new  = opened_new_q;
	assign status      = status_q;

	// Checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while a request is still in the chain");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_cnt_q <= CNT_W'(MAX_CHUNKS))
		else $error("open chunk count beyond chain length");

	a_open_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(open_cnt_q) |-> (done && opened_new && status == ST_PLACED))
		else $error("open count changed without an opening result");

	a_open_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(done && opened_new) |-> (byte_offset == '0))
		else $error("fresh chunk placement not at offset zero");

	a_no_chain_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && too_large) |=> !busy)
		else $error("oversize request entered the chain");

endmodule

// ----- rtl/core/ffca_cell.sv -----
`timescale 1ns / 1ps

module ffca_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ffca_pkg::chain_ctx_t ctx,
	input  ffca_pkg::token_t    tok_in,
	output ffca_pkg::token_t    tok_out
);
	import ffca_pkg::*;

	logic [BYTES_W-1:0] free_q;
	token_t             tok_q;
	token_t             tok_d;
	logic               is_open;
	logic               is_next;
	logic               hit;
	logic               opening;

	// Chunk state of this cell as seen by the passing token
	assign is_open = CNT_W'(tok_in.idx) < ctx.open_cnt;
	assign is_next = CNT_W'(tok_in.idx) == ctx.open_cnt;
	assign hit     = tok_in.valid && !tok_in.placed && is_open
	                 && (BYTES_W'(tok_in.req) <= free_q);
	assign opening = tok_in.valid && !tok_in.placed && is_next;

	// Outgoing token
	always_comb begin
		tok_d     = tok_in;
		tok_d.idx = tok_in.idx + 1'b1;
		if (hit) begin
			tok_d.placed  = 1'b1;
			tok_d.opened  = 1'b0;
			tok_d.hit_idx = tok_in.idx;
			tok_d.offset  = ctx.chunk_bytes - free_q;
		end else if (opening) begin
			tok_d.placed  = 1'b1;
			tok_d.opened  = 1'b1;
			tok_d.hit_idx = tok_in.idx;
			tok_d.offset  = '0;
		end
	end

	// Free byte count of this chunk
	always_ff @(posedge clk) begin
		if (hit) begin
			free_q <= free_q - BYTES_W'(tok_in.req);
		end else if (opening) begin
			free_q <= ctx.chunk_bytes - BYTES_W'(tok_in.req);
		end
	end

	// Token register towards the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

// ----- rtl/core/ffca_chain.sv -----
`timescale 1ns / 1ps

module ffca_chain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ffca_pkg::chain_ctx_t ctx,
	input  ffca_pkg::token_t     tok_in,
	output ffca_pkg::token_t     tok_out
);
	import ffca_pkg::*;

	token_t link [MAX_CHUNKS+1];

	assign link[0] = tok_in;

	// One cell per chunk, token moves one cell per cycle
	for (genvar g = 0; g < MAX_CHUNKS; g++) begin : g_cell
		ffca_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctx     (ctx),
			.tok_in  (link[g]),
			.tok_out (link[g+1])
		);
	end

	assign tok_out = link[MAX_CHUNKS];

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import ffca_pkg::*;

	// One result as the block presents it
	typedef struct packed {
		logic [CHUNK_IDX_W-1:0] idx;
		logic [BYTES_W-1:0]     off;
		logic                   opened;
		logic [STATUS_W-1:0]    st;
	} alloc_result_t;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		alloc_result_t    res;
	} placement_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [BYTES_W-1:0]     cfg_wdata;
	logic                   start;
	logic                   busy;
	logic [REQ_W-1:0]       request_bytes;
	logic                   done;
	logic [CHUNK_IDX_W-1:0] chunk_index;
	logic [BYTES_W-1:0]     byte_offset;
	logic                   opened_new;
	logic [STATUS_W-1:0]    status;

	// Shadow of the allocator state
	logic [BYTES_W-1:0] chunk_cap;
	logic [BYTES_W-1:0] chunk_free [MAX_CHUNKS];
	int                 open_count;

	placement_t placements_due [$];
	int         mismatch_count;
	int         idle_pct;

	first_fit_chunk_allocator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.request_bytes (request_bytes),
		.done          (done),
		.chunk_index   (chunk_index),
		.byte_offset   (byte_offset),
		.opened_new    (opened_new),
		.status        (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// First-fit placement, updating the shadow state
	function automatic alloc_result_t place_request(input logic [REQ_W-1:0] req);
		alloc_result_t r;
		int            i;
		r = '0;
		if (req > chunk_cap) begin
			r.st = ST_TOO_LARGE;
			return r;
		end
		for (i = 0; i < open_count; i++) begin
			if (req <= chunk_free[i]) begin
				r.idx = CHUNK_IDX_W'(i);
				r.off = chunk_cap - chunk_free[i];   // wraps when free exceeds capacity
				chunk_free[i] = chunk_free[i] - req;
				r.st = ST_PLACED;
				return r;
			end
		end
		if (open_count < MAX_CHUNKS) begin
			chunk_free[open_count] = chunk_cap - req;
			r.idx = CHUNK_IDX_W'(open_count);
			r.opened = 1'b1;
			r.st = ST_PLACED;
			open_count++;
			return r;
		end
		r.st = ST_FULL;
		return r;
	endfunction

	// Request mix: mostly sizes that fit, some tiny, some anything
	function automatic logic [REQ_W-1:0] pick_request();
		int top;
		int sel;
		top = (chunk_cap > 255) ? 255 : int'(chunk_cap);
		sel = $urandom_range(99);
		if (sel < 50)
			return REQ_W'($urandom_range(top));
		if (sel < 75)
			return REQ_W'($urandom_range(15));
		return REQ_W'($urandom_range(255));
	endfunction

	// One request transfer, with an optional random idle gap first
	task automatic send_request(input logic [REQ_W-1:0] req);
		int         gap;
		placement_t p;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start         <= 1'b1;
		request_bytes <= req;
		do
			@(posedge clk);
		while (busy);
		p.req = req;
		p.res = place_request(req);
		placements_due.push_back(p);
	endtask

	// Stop sending and let every outstanding result come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (placements_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_chunk_bytes(input logic [BYTES_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		chunk_cap = value;
	endtask

	// Result checker
	always @(posedge clk) begin
		placement_t    p;
		alloc_result_t got;
		if (arst_n && done) begin
			got = {chunk_index, byte_offset, opened_new, status};
			if (placements_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: idx %0d off %0d new %0b st %0d",
						got.idx, got.off, got.opened, got.st);
			end else begin
				p = placements_due.pop_front();
				if (got !== p.res) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch req %0d: expected idx %0d off %0d new %0b st %0d,",
							" got idx %0d off %0d new %0b st %0d"},
							p.req, p.res.idx, p.res.off, p.res.opened, p.res.st,
							got.idx, got.off, got.opened, got.st);
				end
			end
		end
	end

	// Reset capacity: fills, exact fits, zero-byte requests, too large
	task automatic test_reset_capacity();
		idle_pct = 0;
		send_request(8'd0);     // opens chunk 0
		send_request(8'd100);   // exact fit
		send_request(8'd0);     // zero bytes into a full chunk
		send_request(8'd101);
		send_request(8'd255);
		send_request(8'd1);
		send_request(8'd99);
		send_request(8'd60);
		send_request(8'd40);
		send_request(8'd50);
		send_request(8'd30);
		send_request(8'd20);
		send_request(8'd30);    // leaves a chunk with 70 free
		drain();
	endtask

	// Capacity shrunk below open free counts, then zero capacity
	task automatic test_capacity_extremes();
		write_chunk_bytes(BYTES_W'(20));
		send_request(8'd21);
		send_request(8'd20);    // offset wraps
		send_request(8'd5);
		drain();
		write_chunk_bytes(BYTES_W'(0));
		send_request(8'd0);
		send_request(8'd1);
		send_request(8'd128);
		drain();
	endtask

	task automatic test_random_traffic(input logic [BYTES_W-1:0] cap, input int pct,
		input int count);
		int n;
		write_chunk_bytes(cap);
		idle_pct = pct;
		for (n = 0; n < count; n++)
			send_request(pick_request());
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		start         = 1'b0;
		request_bytes = '0;
		chunk_cap     = CHUNK_BYTES_RST;
		open_count    = 0;
		mismatch_count = 0;
		idle_pct      = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_reset_capacity();
		test_capacity_extremes();
		// Spread chunk openings over the phases before the store runs full
		test_random_traffic(BYTES_W'(1000), 0, 300);
		test_random_traffic(BYTES_W'(20), 71, 300);
		test_random_traffic(BYTES_W'(300), 24, 400);
		test_random_traffic(BYTES_W'(100000), 0, 300);
		test_random_traffic(BYTES_W'(131071), 71, 200);
		test_random_traffic(BYTES_W'($urandom_range(131071)), 24, 100);

		repeat (70) @(posedge clk);
		if (mismatch_count == 0 && placements_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end

endmodule
